/* rtl/cob_pkg.sv */
`timescale 1ns / 1ps
// Package: widths, types and limits shared by the contour orientation block.
package cob_pkg;

  localparam int COORD_W    = 16;
  localparam int MAX_POINTS = 4096;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [CNT_W-1:0]   cnt_t;

  // Bounding box and count snapshot that travels with a point down the pipe.
  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
    cnt_t   cnt;
    logic   ovf;
  } bbox_t;

endpackage

/* rtl/cob_point_if.sv */
`timescale 1ns / 1ps
// Interfaces: contour point channel and result channel.
interface cob_point_if import cob_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface cob_result_if import cob_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   clockwise;
  sum_t   shoelace_sum;
  coord_t min_x;
  coord_t min_y;
  coord_t max_x;
  coord_t max_y;
  cnt_t   point_count;
  logic   too_many_points;

  modport source (output valid, clockwise, shoelace_sum, min_x, min_y, max_x, max_y,
                  point_count, too_many_points, input ready);
  modport sink   (input valid, clockwise, shoelace_sum, min_x, min_y, max_x, max_y,
                  point_count, too_many_points, output ready);
endinterface

/* rtl/contour_orientation_and_bounds.sv */
`timescale 1ns / 1ps
// Top level: shoelace orientation, bounding box and point count of a contour.
//
// Usage:
//   point_i streams the points of one closed contour, one per transfer, with
//   last_point set on the final one. Contours follow each other with no gap.
//   result_o carries one result per contour: orientation (clockwise when the
//   signed shoelace sum is at least zero), the sum, the bounding box, the
//   saturated point count and the too-many-points flag.
//   Throughput: one point per cycle. A point is taken every cycle while the
//   result side keeps up; the rate is set by the single 17x17 multiplier
//   stage and the accumulator add, each one register stage.
//   Result path: the input stage loads as the last point transfers, then the
//   result passes through the multiply stage, the accumulate stage and the
//   output register, from which it is presented as valid.
//   Reset clears the contour state and empties the pipeline; the first point
//   can be taken as soon as reset is released.
//   When the receiver stalls, the result waits in the output register. Points
//   that close no contour keep flowing; a second closing point waits in the
//   accumulate stage, and once the pipe fills point_i.ready drops.
module contour_orientation_and_bounds import cob_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cob_point_if.sink    point_i,
  cob_result_if.source result_o
);

  // contour state
  coord_t start_x_q, start_y_q, prev_x_q, prev_y_q;
  coord_t lo_x_q, lo_y_q, hi_x_q, hi_y_q;
  cnt_t   cnt_q;
  logic   ovf_q;
  sum_t   acc_q;

  // stage 1: differences
  logic   v1_q, last1_q;
  diff_t  dx1_q, sy1_q, cdx1_q, csy1_q;
  bbox_t  box1_q;
  // stage 2: products
  logic   v2_q, last2_q;
  prod_t  p1_2_q, p2_2_q;
  bbox_t  box2_q;
  // stage 3: accumulated sum
  logic   v3_q, last3_q;
  sum_t   tot3_q;
  prod_t  p2_3_q;
  bbox_t  box3_q;
  // output register
  logic   out_v_q;
  sum_t   out_sum_q;
  bbox_t  out_box_q;

  logic   out_free, r1, r2, r3, fire_in, first, sat;
  coord_t x, y, sx_now, sy_now;
  bbox_t  box_now;
  sum_t   tot_d, out_sum_d;

  assign out_free = !out_v_q || result_o.ready;
  assign r3       = !v3_q || !last3_q || out_free;
  assign r2       = !v2_q || r3;
  assign r1       = !v1_q || r2;
  assign point_i.ready = r1;
  assign fire_in  = point_i.valid && r1;

  assign x     = point_i.point_x;
  assign y     = point_i.point_y;
  assign first = (cnt_q == '0);
  assign sat   = (cnt_q >= cnt_t'(MAX_POINTS));

  always_comb begin
    sx_now       = first ? x : start_x_q;
    sy_now       = first ? y : start_y_q;
    box_now.lo_x = (first || x < lo_x_q) ? x : lo_x_q;
    box_now.lo_y = (first || y < lo_y_q) ? y : lo_y_q;
    box_now.hi_x = (first || x > hi_x_q) ? x : hi_x_q;
    box_now.hi_y = (first || y > hi_y_q) ? y : hi_y_q;
    box_now.cnt  = sat ? cnt_q : cnt_q + cnt_t'(1);
    box_now.ovf  = ovf_q || sat;
  end

  // contour state: advance on each point, clear after the closing point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      lo_x_q    <= '0;
      lo_y_q    <= '0;
      hi_x_q    <= '0;
      hi_y_q    <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (fire_in) begin
      if (point_i.last_point) begin
        start_x_q <= '0;
        start_y_q <= '0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        lo_x_q    <= '0;
        lo_y_q    <= '0;
        hi_x_q    <= '0;
        hi_y_q    <= '0;
        cnt_q     <= '0;
        ovf_q     <= 1'b0;
      end else begin
        start_x_q <= sx_now;
        start_y_q <= sy_now;
        prev_x_q  <= x;
        prev_y_q  <= y;
        lo_x_q    <= box_now.lo_x;
        lo_y_q    <= box_now.lo_y;
        hi_x_q    <= box_now.hi_x;
        hi_y_q    <= box_now.hi_y;
        cnt_q     <= box_now.cnt;
        ovf_q     <= box_now.ovf;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r1) v1_q <= point_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (out_free) out_v_q <= v3_q && last3_q;
    end
  end

  // stage 1: the first point has no incoming edge, so zero its x step
  always_ff @(posedge clk_i) begin
    if (fire_in) begin
      last1_q <= point_i.last_point;
      dx1_q   <= first ? diff_t'(0) : diff_t'(x) - diff_t'(prev_x_q);
      sy1_q   <= diff_t'(y) + diff_t'(prev_y_q);
      cdx1_q  <= diff_t'(sx_now) - diff_t'(x);
      csy1_q  <= diff_t'(sy_now) + diff_t'(y);
      box1_q  <= box_now;
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (v1_q && r2) begin
      last2_q <= last1_q;
      p1_2_q  <= dx1_q * sy1_q;
      p2_2_q  <= cdx1_q * csy1_q;
      box2_q  <= box1_q;
    end
  end

  // stage 3 and the running sum; drop the sum after the closing point
  assign tot_d = acc_q + sum_t'(p1_2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (v2_q && r3) begin
      acc_q <= last2_q ? sum_t'(0) : tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      last3_q <= last2_q;
      tot3_q  <= tot_d;
      p2_3_q  <= p2_2_q;
      box3_q  <= box2_q;
    end
  end

  // output register: add the closing edge
  assign out_sum_d = tot3_q + sum_t'(p2_3_q);

  always_ff @(posedge clk_i) begin
    if (v3_q && last3_q && out_free) begin
      out_sum_q <= out_sum_d;
      out_box_q <= box3_q;
    end
  end

  assign result_o.valid           = out_v_q;
  assign result_o.clockwise       = !out_sum_q[SUM_W-1];
  assign result_o.shoelace_sum    = out_sum_q;
  assign result_o.min_x           = out_box_q.lo_x;
  assign result_o.min_y           = out_box_q.lo_y;
  assign result_o.max_x           = out_box_q.hi_x;
  assign result_o.max_y           = out_box_q.hi_y;
  assign result_o.point_count     = out_box_q.cnt;
  assign result_o.too_many_points = out_box_q.ovf;

  // checks
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && r3 && last2_q) |=> (acc_q == '0))
    else $error("running sum not cleared after closing point");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(MAX_POINTS))
    else $error("point count beyond maximum");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(v3_q && last3_q))
    else $error("result raised without a closing point");

  a_close_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_in && point_i.last_point) |=> (cnt_q == '0 && !ovf_q))
    else $error("contour state not cleared after closing point");

endmodule

/* tb/cob_contour_sb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard package: contour summary predictor and result checker.
package cob_contour_sb_pkg;
  import cob_pkg::*;

  typedef struct packed {
    logic   cw;
    sum_t   sum;
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
    cnt_t   cnt;
    logic   ovf;
  } contour_summary_t;

  class contour_scoreboard;
    contour_summary_t summaries_due[$];
    int               mismatches;

    coord_t first_x, first_y, prev_x, prev_y;
    coord_t lo_x, lo_y, hi_x, hi_y;
    sum_t   edge_acc;
    cnt_t   seen;
    logic   ovf;

    function new();
      mismatches = 0;
      clear_contour();
    endfunction

    function void clear_contour();
      first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
      lo_x = '0; lo_y = '0; hi_x = '0; hi_y = '0;
      edge_acc = '0;
      seen = '0;
      ovf = 1'b0;
    endfunction

    // (a - b) * (c + d), sign-extended to the accumulator width
    function sum_t edge_term(coord_t a, coord_t b, coord_t c, coord_t d);
      diff_t dx;
      diff_t sy;
      prod_t p;
      dx = diff_t'(a) - diff_t'(b);
      sy = diff_t'(c) + diff_t'(d);
      p  = dx * sy;
      return sum_t'(p);
    endfunction

    function void take_point(coord_t x, coord_t y, logic last);
      contour_summary_t s;
      if (seen == '0) begin
        first_x = x; first_y = y;
        lo_x = x; hi_x = x;
        lo_y = y; hi_y = y;
        edge_acc = '0;
      end else begin
        edge_acc = edge_acc + edge_term(x, prev_x, y, prev_y);
        if (x < lo_x) lo_x = x;
        if (y < lo_y) lo_y = y;
        if (x > hi_x) hi_x = x;
        if (y > hi_y) hi_y = y;
      end
      prev_x = x;
      prev_y = y;
      // saturate the count and flag the excess points
      if (seen >= cnt_t'(MAX_POINTS)) ovf = 1'b1;
      else seen = seen + cnt_t'(1);
      if (last) begin
        s.sum  = edge_acc + edge_term(first_x, x, first_y, y);
        s.cw   = ~s.sum[SUM_W-1];
        s.lo_x = lo_x;
        s.lo_y = lo_y;
        s.hi_x = hi_x;
        s.hi_y = hi_y;
        s.cnt  = seen;
        s.ovf  = ovf;
        summaries_due = {summaries_due, s};
        clear_contour();
      end
    endfunction

    function void field_check(string field, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void match_summary(contour_summary_t got);
      contour_summary_t want;
      if (summaries_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual sum %0d count %0d",
                 $time, $signed(got.sum), got.cnt);
        return;
      end
      want = summaries_due.pop_front();
      field_check("clockwise", want.cw, got.cw);
      field_check("shoelace_sum", $signed(want.sum), $signed(got.sum));
      field_check("min_x", $signed(want.lo_x), $signed(got.lo_x));
      field_check("min_y", $signed(want.lo_y), $signed(got.lo_y));
      field_check("max_x", $signed(want.hi_x), $signed(got.hi_x));
      field_check("max_y", $signed(want.hi_y), $signed(got.hi_y));
      field_check("point_count", want.cnt, got.cnt);
      field_check("too_many_points", want.ovf, got.ovf);
    endfunction

    function int pending();
      return summaries_due.size();
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top: drives contours into the orientation block and checks each summary.
module tb_top;
  import cob_pkg::*;
  import cob_contour_sb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  cob_point_if  pts ();
  cob_result_if res ();

  contour_orientation_and_bounds u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pts),
    .result_o (res)
  );

  contour_scoreboard sb;

  int items_sent   = 0;
  int gap_odds     = 0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int next_gap();
    if (calm || gap_odds == 0) return 0;
    if ($urandom_range(0, gap_odds - 1) == 0) return $urandom_range(1, 17);
    return 0;
  endfunction

  function automatic coord_t pick_coord(bit extreme);
    if (extreme && $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 5))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        3: return 16'shffff;
        4: return 16'sh8001;
        default: return 16'sh7ffe;
      endcase
    end
    return coord_t'($urandom);
  endfunction

  // Hold valid across back-to-back transfers; drop it only for a gap.
  task automatic send_point(coord_t x, coord_t y, logic last);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pts.valid      <= 1'b1;
    pts.point_x    <= x;
    pts.point_y    <= y;
    pts.last_point <= last;
    do @(posedge clk_i); while (!pts.ready);
    sb.take_point(x, y, last);
    items_sent++;
  endtask

  task automatic send_xy(int x, int y, bit last);
    send_point(coord_t'(x), coord_t'(y), last);
  endtask

  task automatic send_rectangle();
    coord_t x0, y0, x1, y1;
    x0 = pick_coord(1'b1);
    y0 = pick_coord(1'b1);
    x1 = x0 + coord_t'($urandom_range(0, 2000));
    y1 = y0 + coord_t'($urandom_range(0, 2000));
    if ($urandom_range(0, 1) == 1) begin
      send_point(x0, y0, 1'b0); send_point(x0, y1, 1'b0);
      send_point(x1, y1, 1'b0); send_point(x1, y0, 1'b1);
    end else begin
      send_point(x0, y0, 1'b0); send_point(x1, y0, 1'b0);
      send_point(x1, y1, 1'b0); send_point(x0, y1, 1'b1);
    end
  endtask

  task automatic send_contour(int n, int style);
    coord_t x, y;
    if (style == 3) begin
      send_rectangle();
      return;
    end
    x = pick_coord(style == 2);
    y = pick_coord(style == 2);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if (style == 1) begin
          // small steps trace a plausible outline
          x = x + coord_t'($urandom_range(0, 64)) - 16'sd32;
          y = y + coord_t'($urandom_range(0, 64)) - 16'sd32;
        end else begin
          x = pick_coord(style == 2);
          y = pick_coord(style == 2);
        end
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  task automatic send_random_contour();
    int r, n;
    r = $urandom_range(0, 3);
    gap_odds = (r == 0) ? 0 : r * 3;
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 12);
    else if (r < 95) n = $urandom_range(13, 40);
    else n = $urandom_range(1, 3);
    send_contour(n, $urandom_range(0, 3));
  endtask

  // Result side: random stalls, one long hold-off on request, none when calm.
  initial begin
    int stall_left;
    int hold_left;
    int ready_odds;
    bit hold_done;
    contour_summary_t got;
    stall_left = 0;
    hold_left  = 0;
    ready_odds = 4;
    hold_done  = 1'b0;
    res.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) begin
        got.cw   = res.clockwise;
        got.sum  = res.shoelace_sum;
        got.lo_x = res.min_x;
        got.lo_y = res.min_y;
        got.hi_x = res.max_x;
        got.hi_y = res.max_y;
        got.cnt  = res.point_count;
        got.ovf  = res.too_many_points;
        sb.match_summary(got);
      end
      if ($urandom_range(0, 63) == 0) ready_odds = ($urandom_range(0, 2) == 0) ? 0 :
                                                   $urandom_range(2, 12);
      if (hold_request && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (calm) begin
        res.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (ready_odds != 0 && $urandom_range(0, ready_odds - 1) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin
    sb = new();
    rst_ni         = 1'b0;
    pts.valid      = 1'b0;
    pts.point_x    = '0;
    pts.point_y    = '0;
    pts.last_point = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point at opposite extremes
    send_xy(-32768, 32767, 1'b1);
    // two points: sum stays zero
    send_xy(32767, -32768, 1'b0);
    send_xy(-32768, 32767, 1'b1);
    // small square, one way round and the other
    send_xy(0, 0, 1'b0);  send_xy(0, 10, 1'b0);
    send_xy(10, 10, 1'b0); send_xy(10, 0, 1'b1);
    send_xy(0, 0, 1'b0);  send_xy(10, 0, 1'b0);
    send_xy(10, 10, 1'b0); send_xy(0, 10, 1'b1);
    // full-range square gives the largest edge terms
    send_xy(-32768, -32768, 1'b0); send_xy(-32768, 32767, 1'b0);
    send_xy(32767, 32767, 1'b0);   send_xy(32767, -32768, 1'b1);
    // repeated points
    send_xy(5, 5, 1'b0); send_xy(5, 5, 1'b0); send_xy(5, 5, 1'b1);

    // count boundary: exactly the maximum, then one past it
    gap_odds = 20;
    send_contour(MAX_POINTS, 0);
    send_contour(MAX_POINTS + 1, 2);

    // long receiver hold-off while short contours keep coming
    gap_odds = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) send_contour($urandom_range(1, 2), 0);

    while (items_sent < 17 + 2 * MAX_POINTS + 1 + 550) send_random_contour();
    calm = 1'b1;
    while (items_sent < 17 + 2 * MAX_POINTS + 1 + 650) send_random_contour();
    pts.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
